FILE: sv/bfc_pkg.sv
// types, widths and defaults shared by the frustum culling block
package bfc_pkg;

  localparam int FIELD_W = 16;  // width of a chunk coordinate field
  localparam int ENTRY_W = 32;  // matrix entry, signed q12.20
  localparam int COEF_W  = ENTRY_W + 1;  // plane coefficient, sum or difference of two entries

  localparam int DEF_CHUNK_WIDTH  = 16;
  localparam int DEF_CHUNK_DEPTH  = 16;
  localparam int DEF_CHUNK_HEIGHT = 256;
  localparam int DEF_COORD_BITS   = 16;

  localparam int NUM_PLANES = 6;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [3:0]                 entry_index;
    logic signed [ENTRY_W-1:0]  entry_value;
    logic signed [FIELD_W-1:0]  chunk_x;
    logic signed [FIELD_W-1:0]  chunk_z;
    logic                       present;
  } item_t;

  typedef struct packed {
    logic                       visible;
    logic signed [FIELD_W-1:0]  tested_x;
    logic signed [FIELD_W-1:0]  tested_z;
  } result_t;

  // what travels from cell to cell each cycle
  typedef struct packed {
    logic                       valid;
    logic                       load;
    logic [3:0]                 entry_index;
    logic signed [ENTRY_W-1:0]  entry_value;
    logic signed [FIELD_W-1:0]  chunk_x;
    logic signed [FIELD_W-1:0]  chunk_z;
    logic                       visible;
  } tok_t;

endpackage

FILE: sv/bfc_cell.sv
// one plane cell: holds its matrix entries and plane, tests a box over three stages
module bfc_cell import bfc_pkg::*; #(
  parameter int PLANE        = 0,
  parameter int CHUNK_WIDTH  = DEF_CHUNK_WIDTH,
  parameter int CHUNK_DEPTH  = DEF_CHUNK_DEPTH,
  parameter int CHUNK_HEIGHT = DEF_CHUNK_HEIGHT,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  tok_t up,
  output tok_t down
);

  localparam logic       MINUS = (PLANE % 2) != 0;
  localparam logic [1:0] ROWK  = 2'(PLANE / 2);
  localparam logic [1:0] ROW3  = 2'd3;

  localparam int SW   = COORD_BITS + 1;        // box corner in chunk units
  localparam int PW   = COEF_W + SW;
  localparam int WB   = $clog2(CHUNK_WIDTH + 1) + 1;
  localparam int DB   = $clog2(CHUNK_DEPTH + 1) + 1;
  localparam int HB   = $clog2(CHUNK_HEIGHT + 1) + 1;
  localparam int QXW  = PW + WB;
  localparam int QZW  = PW + DB;
  localparam int OFFW = COEF_W + HB + 1;
  localparam int MXW  = (QXW > QZW) ? ((QXW > OFFW) ? QXW : OFFW)
                                    : ((QZW > OFFW) ? QZW : OFFW);
  localparam int ACCW = MXW + 2;

  localparam logic signed [WB-1:0] W_C = WB'(CHUNK_WIDTH);
  localparam logic signed [DB-1:0] D_C = DB'(CHUNK_DEPTH);
  localparam logic signed [HB-1:0] H_C = HB'(CHUNK_HEIGHT);

  // e3 holds row 3 of each column, ek holds row k
  logic signed [ENTRY_W-1:0] e3 [4];
  logic signed [ENTRY_W-1:0] ek [4];
  logic signed [COEF_W-1:0]  coef [4];  // x, y, z normal and offset
  logic signed [ENTRY_W-1:0] e3_next [4];
  logic signed [ENTRY_W-1:0] ek_next [4];
  logic signed [COEF_W-1:0]  coef_next [4];
  logic signed [OFFW-1:0]    off;

  tok_t                  tok_b, tok_c, tok_d;
  tok_t                  tok_d_next;
  logic signed [PW-1:0]  px, pz;
  logic signed [QXW-1:0] qx;
  logic signed [QZW-1:0] qz;

  logic [1:0] col, row;
  logic       load_hit;

  logic signed [COORD_BITS-1:0] xc, zc;
  logic signed [SW-1:0]         xsel, zsel;
  logic                         nx_pos, ny_pos, nz_pos;
  logic signed [OFFW-1:0]       off_next;
  logic signed [ACCW-1:0]       acc;

  assign col      = up.entry_index[3:2];
  assign row      = up.entry_index[1:0];
  assign load_hit = up.valid && up.load;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      e3_next[c] = e3[c];
      ek_next[c] = ek[c];
      if (load_hit && col == 2'(c) && row == ROW3) begin
        e3_next[c] = up.entry_value;
      end
      if (load_hit && col == 2'(c) && row == ROWK) begin
        ek_next[c] = up.entry_value;
      end
      coef_next[c] = MINUS ? (COEF_W'(e3_next[c]) - COEF_W'(ek_next[c]))
                           : (COEF_W'(e3_next[c]) + COEF_W'(ek_next[c]));
    end
  end

  // coordinates are the low COORD_BITS of the field, zero-filled above it
  always_comb begin
    for (int i = 0; i < COORD_BITS; i++) begin
      xc[i] = (i < FIELD_W) ? up.chunk_x[i] : 1'b0;
      zc[i] = (i < FIELD_W) ? up.chunk_z[i] : 1'b0;
    end
  end

  assign nx_pos = !coef[0][COEF_W-1] && (coef[0] != '0);
  assign ny_pos = !coef[1][COEF_W-1] && (coef[1] != '0);
  assign nz_pos = !coef[2][COEF_W-1] && (coef[2] != '0);

  // positive normal component picks the far face of the box
  assign xsel = nx_pos ? (SW'(xc) + SW'(1)) : SW'(xc);
  assign zsel = nz_pos ? (SW'(zc) + SW'(1)) : SW'(zc);

  // height term is folded into the offset, refreshed as a load passes stage b
  assign off_next = OFFW'(coef[3])
                  + (ny_pos ? (OFFW'(coef[1]) * OFFW'(H_C)) : OFFW'(0));

  assign acc = ACCW'(qx) + ACCW'(qz) + ACCW'(off);

  always_comb begin
    tok_d_next = tok_c;
    if (tok_c.valid && !tok_c.load) begin
      tok_d_next.visible = tok_c.visible && !acc[ACCW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        e3[c]   <= '0;
        ek[c]   <= '0;
        coef[c] <= '0;
      end
      off   <= '0;
      tok_b <= '0;
      tok_c <= '0;
      tok_d <= '0;
    end else if (en) begin
      for (int c = 0; c < 4; c++) begin
        e3[c]   <= e3_next[c];
        ek[c]   <= ek_next[c];
        coef[c] <= coef_next[c];
      end
      if (tok_b.valid && tok_b.load) begin
        off <= off_next;
      end
      tok_b <= up;
      tok_c <= tok_b;
      tok_d <= tok_d_next;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      px <= PW'(coef[0]) * PW'(xsel);
      pz <= PW'(coef[2]) * PW'(zsel);
      qx <= QXW'(px) * QXW'(W_C);
      qz <= QZW'(pz) * QZW'(D_C);
    end
  end

  assign down = tok_d;

endmodule

FILE: sv/box_frustum_cull.sv
// box_frustum_cull: six plane cells in a row test one chunk box per cycle
// a test transaction passes every cell's registered stages before its result shows
// one transaction per cycle unless stalled; matrix loads flow down the same chain
// a stalled result freezes the whole chain, the output register is the last cell stage
// reset clears the matrix and all planes to zero and empties the chain
module box_frustum_cull import bfc_pkg::*; #(
  parameter int CHUNK_WIDTH  = DEF_CHUNK_WIDTH,
  parameter int CHUNK_DEPTH  = DEF_CHUNK_DEPTH,
  parameter int CHUNK_HEIGHT = DEF_CHUNK_HEIGHT,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  tok_t chain [NUM_PLANES+1];
  logic en;

  assign en           = !result_valid || result_ready;
  assign item_ready   = en && !rst;
  assign result_valid = chain[NUM_PLANES].valid && !chain[NUM_PLANES].load;

  always_comb begin
    chain[0].valid       = item_valid && en;
    chain[0].load        = (item.mode == MODE_LOAD);
    chain[0].entry_index = item.entry_index;
    chain[0].entry_value = item.entry_value;
    chain[0].chunk_x     = item.chunk_x;
    chain[0].chunk_z     = item.chunk_z;
    chain[0].visible     = item.present;
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    bfc_cell #(
      .PLANE        (p),
      .CHUNK_WIDTH  (CHUNK_WIDTH),
      .CHUNK_DEPTH  (CHUNK_DEPTH),
      .CHUNK_HEIGHT (CHUNK_HEIGHT),
      .COORD_BITS   (COORD_BITS)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .up   (chain[p]),
      .down (chain[p+1])
    );
  end

  assign result.visible  = chain[NUM_PLANES].visible;
  assign result.tested_x = chain[NUM_PLANES].chunk_x;
  assign result.tested_z = chain[NUM_PLANES].chunk_z;

endmodule
